[rtl/core/sefc_pkg.sv]
// Shared types and constants for the STX/ETX frame checker.
package sefc_pkg;

    // Longest frame length that the byte counter tracks before it saturates
    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    localparam logic [7:0] STX_BYTE  = 8'h02;
    localparam logic [7:0] ETX_BYTE  = 8'h03;
    localparam int         MIN_FRAME = 6;

    // Frame byte positions
    localparam logic [CNT_W-1:0] POS_START   = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_ADDR    = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_CMD     = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_METER_L = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_METER_H = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_FRAME);
    // Frame length is count plus the final byte
    localparam logic [CNT_W-1:0] CNT_SHORT   = CNT_W'(MIN_FRAME - 1);

    typedef enum logic [2:0] {
        ST_VALID   = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NO_STX  = 3'd2,
        ST_NO_ETX  = 3'd3,
        ST_BAD_SUM = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  station_address;
        logic [7:0]  command_code;
        logic [15:0] meter_value;
    } sefc_result_t;

endpackage

[rtl/core/sefc_frame_state.sv]
// Per-frame state: byte count, running XOR, captured fields and frame checks.
module sefc_frame_state (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic                  end_of_frame,
    output sefc_pkg::sefc_result_t result
);
    import sefc_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       start_reg, start_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      meter_reg, meter_next;
    status_t          status;

    // Frame checks, in priority order
    always_comb begin
        if (byte_count_reg < CNT_SHORT) begin
            status = ST_SHORT;
        end else if (start_reg != STX_BYTE) begin
            status = ST_NO_STX;
        end else if (rx_byte != ETX_BYTE) begin
            status = ST_NO_ETX;
        end else if (held_reg != xor_reg) begin
            status = ST_BAD_SUM;
        end else begin
            status = ST_VALID;
        end
    end

    // Rejected frames report zero fields
    always_comb begin
        result.status = status;
        if (status == ST_VALID) begin
            result.station_address = addr_reg;
            result.command_code    = cmd_reg;
            result.meter_value     = meter_reg;
        end else begin
            result.station_address = '0;
            result.command_code    = '0;
            result.meter_value     = '0;
        end
    end

    // State update; the final byte clears everything for the next frame
    always_comb begin
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        held_next       = held_reg;
        start_next      = start_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        meter_next      = meter_reg;
        if (step) begin
            if (end_of_frame) begin
                byte_count_next = '0;
                xor_next        = '0;
                held_next       = '0;
                start_next      = '0;
                addr_next       = '0;
                cmd_next        = '0;
                meter_next      = '0;
            end else begin
                if (byte_count_reg != POS_START) begin
                    xor_next = xor_reg ^ held_reg;
                end
                held_next = rx_byte;
                if (byte_count_reg == POS_START) begin
                    start_next = rx_byte;
                end
                if (byte_count_reg == POS_ADDR) begin
                    addr_next = rx_byte;
                end
                if (byte_count_reg == POS_CMD) begin
                    cmd_next = rx_byte;
                end
                if (byte_count_reg == POS_METER_L) begin
                    meter_next = {meter_reg[15:8], rx_byte};
                end
                if (byte_count_reg == POS_METER_H) begin
                    meter_next = {rx_byte, meter_reg[7:0]};
                end
                if (byte_count_reg < CNT_MAX) begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            xor_reg        <= '0;
            held_reg       <= '0;
            start_reg      <= '0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            meter_reg      <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            xor_reg        <= xor_next;
            held_reg       <= held_next;
            start_reg      <= start_next;
            addr_reg       <= addr_next;
            cmd_reg        <= cmd_next;
            meter_reg      <= meter_next;
        end
    end

endmodule

[rtl/core/sefc_result_reg.sv]
// Output register holding one finished result item until it is taken.
module sefc_result_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  sefc_pkg::sefc_result_t result,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [7:0]             m_station_address,
    output logic [7:0]             m_command_code,
    output logic [15:0]            m_meter_value
);
    import sefc_pkg::*;

    logic         valid_reg, valid_next;
    sefc_result_t data_reg;

    assign free = !valid_reg || m_ready;

    // Valid sets on load, clears once the item is taken
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid           = valid_reg;
    assign m_status          = data_reg.status;
    assign m_station_address = data_reg.station_address;
    assign m_command_code    = data_reg.command_code;
    assign m_meter_value     = data_reg.meter_value;

endmodule

[rtl/core/stx_etx_frame_checker.sv]
// Top level of the STX/ETX response frame checker with XOR checksum.
// Frame bytes enter one per item, the final byte flagged by s_end_of_frame.
// Each byte is registered in the input stage, then folded into the frame
// state when that stage advances; the final byte produces one result item
// (status, address, command, meter value) in an output register. One byte
// is taken every cycle while no finished result waits for m_ready. The input
// register and the output register stall together only while a result waits
// for m_ready. No clearing pass is needed after reset.
module stx_etx_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_station_address,
    output logic [7:0]  m_command_code,
    output logic [15:0] m_meter_value
);
    import sefc_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_free;
    logic         step;
    logic         load;
    sefc_result_t result;

    // Input stage advances whenever the output side can take a result
    assign step    = in_valid_reg && out_free;
    assign load    = step && in_last_reg;
    assign s_ready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_end_of_frame;
        end
    end

    sefc_frame_state u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .end_of_frame (in_last_reg),
        .result       (result)
    );

    sefc_result_reg u_result (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (load),
        .result            (result),
        .free              (out_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_station_address (m_station_address),
        .m_command_code    (m_command_code),
        .m_meter_value     (m_meter_value)
    );

    // Input back-pressure only comes from a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");

    // A new result only follows a final byte in the input stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(in_valid_reg && in_last_reg))
        else $error("result without a final byte");

    // Rejected frames carry zero fields
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_VALID) |->
            (m_station_address == 8'd0 && m_command_code == 8'd0 && m_meter_value == 16'd0))
        else $error("rejected frame with nonzero fields");

endmodule
